// ----- sv/emf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emf_pkg
// Shared constants, register codes and sideband types of the evidence mass
// fusion block.
// ----------------------------------------------------------------------------
package emf_pkg;

  // fixed point format of the mass parts
  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned PART_W    = 16;
  localparam logic [PART_W-1:0] ONE_VAL = PART_W'(1 << FRAC_BITS);

  // datapath widths
  localparam int unsigned PROD_W  = 2 * PART_W;   // one product of two parts
  localparam int unsigned CSUM_W  = PROD_W + 1;   // conflict product sum
  localparam int unsigned SUM_W   = PROD_W + 2;   // sum of up to three products
  localparam int unsigned CRAW_W  = CSUM_W - FRAC_BITS;
  localparam int unsigned CONF_W  = 17;           // conflict_mass field
  localparam int unsigned EPS_W   = 10;
  localparam int unsigned SW_W    = 16;
  localparam int unsigned S_W     = PART_W + 1;   // sum of three clamped parts
  localparam int unsigned NUM2_W  = PART_W + FRAC_BITS;
  localparam int unsigned LANES   = 3;
  localparam logic [CONF_W-1:0] CONF_MAX = '1;

  // reset values of the registers
  localparam logic [SW_W-1:0]  SWITCH_RST = SW_W'(29491);
  localparam logic [EPS_W-1:0] EPS_RST    = EPS_W'(1);

  // register index codes
  typedef enum logic {
    REG_CONFLICT_SWITCH = 1'b0,
    REG_EPSILON         = 1'b1
  } emf_reg_e;

  // sideband carried beside the first divider
  typedef struct packed {
    logic              yager;
    logic [CONF_W-1:0] conflict;
  } emf_side_t;

  // sideband carried beside the second divider
  typedef struct packed {
    logic              vacuous;
    logic              yager;
    logic [CONF_W-1:0] conflict;
  } emf_seal_side_t;

endpackage
`default_nettype wire

// ----- sv/emf_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emf_div_pipe
// Pipelined restoring divider, one quotient bit per stage, several lanes that
// share one divisor. Flags lanes whose quotient does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module emf_div_pipe import emf_pkg::*; #(
  parameter int unsigned LANE_N = 3,
  parameter int unsigned NUM_W  = 34,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned QUO_W  = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [LANE_N-1:0][NUM_W-1:0]       num_i,
  input  wire logic [DEN_W-1:0]                   den_i,
  input  wire logic [SIDE_W-1:0]                  side_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [LANE_N-1:0][QUO_W-1:0]            quo_o,
  output logic [LANE_N-1:0]                       over_o,
  output logic [SIDE_W-1:0]                       side_o
);

  localparam int unsigned WIDE_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [QUO_W-1:0]                 vld_q;
  logic [QUO_W:0]                   adv;
  logic [LANE_N-1:0][NUM_W-1:0]     rem_q  [QUO_W];
  logic [LANE_N-1:0][QUO_W-1:0]     quo_q  [QUO_W];
  logic [LANE_N-1:0]                over_q [QUO_W];
  logic [DEN_W-1:0]                 den_q  [QUO_W];
  logic [SIDE_W-1:0]                side_q [QUO_W];

  // a stage moves when it is empty or the next one moves
  assign adv[QUO_W] = out_ready_i;
  assign in_ready_o = adv[0];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic                             vld_in;
    logic [LANE_N-1:0][NUM_W-1:0]     rem_in;
    logic [LANE_N-1:0][QUO_W-1:0]     quo_in;
    logic [LANE_N-1:0]                over_in;
    logic [DEN_W-1:0]                 den_in;
    logic [SIDE_W-1:0]                side_in;
    logic [WIDE_W-1:0]                den_sh;
    logic [LANE_N-1:0][NUM_W-1:0]     rem_d;
    logic [LANE_N-1:0][QUO_W-1:0]     quo_d;

    assign adv[k] = !vld_q[k] || adv[k+1];

    if (k == 0) begin : g_first
      // quotient too wide for the stages
      always_comb begin
        for (int l = 0; l < LANE_N; l++) begin
          over_in[l] = WIDE_W'(num_i[l]) >= (WIDE_W'(den_i) << QUO_W);
        end
      end
      assign vld_in  = in_valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign over_in = over_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign den_sh = WIDE_W'(den_in) << (QUO_W - 1 - k);

    // one restoring step per lane
    always_comb begin
      for (int l = 0; l < LANE_N; l++) begin
        rem_d[l] = rem_in[l];
        quo_d[l] = quo_in[l];
        if (WIDE_W'(rem_in[l]) >= den_sh) begin
          rem_d[l] = NUM_W'(WIDE_W'(rem_in[l]) - den_sh);
          quo_d[l][QUO_W-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && vld_in) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        over_q[k] <= over_in;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign out_valid_o = vld_q[QUO_W-1];
  assign quo_o       = quo_q[QUO_W-1];
  assign over_o      = over_q[QUO_W-1];
  assign side_o      = side_q[QUO_W-1];

endmodule
`default_nettype wire

// ----- sv/emf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emf_front
// Products of the mass parts, conflict, rule choice and the dividends and
// divisor for the combination step. Three register stages.
// ----------------------------------------------------------------------------
module emf_front import emf_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [SW_W-1:0]              conflict_switch_i,
  input  wire logic [EPS_W-1:0]             epsilon_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [PART_W-1:0]            a_occupied_i,
  input  wire logic [PART_W-1:0]            a_free_i,
  input  wire logic [PART_W-1:0]            a_unknown_i,
  input  wire logic [PART_W-1:0]            b_occupied_i,
  input  wire logic [PART_W-1:0]            b_free_i,
  input  wire logic [PART_W-1:0]            b_unknown_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [LANES-1:0][SUM_W-1:0]       num_o,
  output logic [PART_W-1:0]                 den_o,
  output emf_side_t                         side_o
);

  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  // stage 1: the nine part products
  logic [PROD_W-1:0] aobf_q, afbo_q, aobo_q, aobu_q, aubo_q, afbf_q, afbu_q, aubf_q, aubu_q;

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      aobf_q <= PROD_W'(a_occupied_i) * PROD_W'(b_free_i);
      afbo_q <= PROD_W'(a_free_i) * PROD_W'(b_occupied_i);
      aobo_q <= PROD_W'(a_occupied_i) * PROD_W'(b_occupied_i);
      aobu_q <= PROD_W'(a_occupied_i) * PROD_W'(b_unknown_i);
      aubo_q <= PROD_W'(a_unknown_i) * PROD_W'(b_occupied_i);
      afbf_q <= PROD_W'(a_free_i) * PROD_W'(b_free_i);
      afbu_q <= PROD_W'(a_free_i) * PROD_W'(b_unknown_i);
      aubf_q <= PROD_W'(a_unknown_i) * PROD_W'(b_free_i);
      aubu_q <= PROD_W'(a_unknown_i) * PROD_W'(b_unknown_i);
    end
  end

  // stage 2: product sums
  logic [CSUM_W-1:0] c2_q;
  logic [SUM_W-1:0]  o2_q, f2_q;
  logic [PROD_W-1:0] u2_q;

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      c2_q <= CSUM_W'(aobf_q) + CSUM_W'(afbo_q);
      o2_q <= SUM_W'(aobo_q) + SUM_W'(aobu_q) + SUM_W'(aubo_q);
      f2_q <= SUM_W'(afbf_q) + SUM_W'(afbu_q) + SUM_W'(aubf_q);
      u2_q <= aubu_q;
    end
  end

  // stage 3: rule choice and divider operands
  logic [CRAW_W-1:0] c_raw;
  logic [PART_W-1:0] thr;
  logic              yager_d;
  emf_side_t         side_d;
  logic [LANES-1:0][SUM_W-1:0] num_d;
  logic [PART_W-1:0] den_d;

  always_comb begin
    c_raw = c2_q[CSUM_W-1:FRAC_BITS];
    // a tolerance at or above one leaves a threshold of zero
    thr   = (PART_W'(epsilon_i) >= ONE_VAL) ? '0 : ONE_VAL - PART_W'(epsilon_i);
    yager_d = (c_raw >= CRAW_W'(conflict_switch_i)) || (c_raw >= CRAW_W'(thr));
    side_d.yager    = yager_d;
    side_d.conflict = (c_raw > CRAW_W'(CONF_MAX)) ? CONF_MAX : CONF_W'(c_raw);
    num_d[0] = o2_q;
    num_d[1] = f2_q;
    // yager moves the conflict into unknown and divides by one
    num_d[2] = yager_d ? SUM_W'(u2_q) + SUM_W'(c2_q) : SUM_W'(u2_q);
    den_d    = yager_d ? ONE_VAL : ONE_VAL - c_raw[PART_W-1:0];
  end

  logic [LANES-1:0][SUM_W-1:0] num_q;
  logic [PART_W-1:0]           den_q;
  emf_side_t                   side_q;

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign num_o       = num_q;
  assign den_o       = den_q;
  assign side_o      = side_q;

endmodule
`default_nettype wire

// ----- sv/emf_seal.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// emf_seal
// Clamps the combined parts, sums them, normalizes each part by the sum with
// a pipelined divider (vacuous at a near-zero sum) and registers the result.
// ----------------------------------------------------------------------------
module emf_seal import emf_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [EPS_W-1:0]             epsilon_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [LANES-1:0][PART_W-1:0] quo_i,
  input  wire logic [LANES-1:0]             over_i,
  input  wire emf_side_t                    side_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [PART_W-1:0]                 fused_occupied_o,
  output logic [PART_W-1:0]                 fused_free_o,
  output logic [PART_W-1:0]                 fused_unknown_o,
  output logic [CONF_W-1:0]                 conflict_mass_o,
  output logic                              yager_applied_o
);

  logic                          sv_q;
  logic                          adv_s;
  logic                          div_ready;
  logic [LANES-1:0][PART_W-1:0]  part_d, part_q;
  logic [S_W-1:0]                sum_d, sum_q;
  emf_seal_side_t                side_d, side_q;

  assign adv_s      = !sv_q || div_ready;
  assign in_ready_o = adv_s;

  // clamp to one, sum, near-zero check
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      part_d[l] = (over_i[l] || quo_i[l] > ONE_VAL) ? ONE_VAL : quo_i[l];
    end
    sum_d = S_W'(part_d[0]) + S_W'(part_d[1]) + S_W'(part_d[2]);
    side_d.vacuous  = sum_d <= S_W'(epsilon_i);
    side_d.yager    = side_i.yager;
    side_d.conflict = side_i.conflict;
  end

  always_ff @(posedge clk_i) begin
    if (adv_s && in_valid_i) begin
      part_q <= part_d;
      sum_q  <= sum_d;
      side_q <= side_d;
    end
  end

  // rounded numerators x * one + s / 2
  logic [LANES-1:0][NUM2_W-1:0] num2;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num2[l] = (NUM2_W'(part_q[l]) << FRAC_BITS) + NUM2_W'(sum_q >> 1);
    end
  end

  logic                          div_valid;
  logic                          adv_o;
  logic [LANES-1:0][PART_W-1:0]  quo2;
  logic [LANES-1:0]              over2;
  logic [$bits(emf_seal_side_t)-1:0] side2_raw;
  emf_seal_side_t                side2;

  emf_div_pipe #(
    .LANE_N (LANES),
    .NUM_W  (NUM2_W),
    .DEN_W  (S_W),
    .QUO_W  (PART_W),
    .SIDE_W ($bits(emf_seal_side_t))
  ) u_norm_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sv_q),
    .in_ready_o  (div_ready),
    .num_i       (num2),
    .den_i       (sum_q),
    .side_i      (side_q),
    .out_valid_o (div_valid),
    .out_ready_i (adv_o),
    .quo_o       (quo2),
    .over_o      (over2),
    .side_o      (side2_raw)
  );

  assign side2 = emf_seal_side_t'(side2_raw);

  // output register
  logic                 ov_q;
  logic [PART_W-1:0]    fo_q, ff_q, fu_q;
  logic [CONF_W-1:0]    conf_q;
  logic                 yager_q;

  assign adv_o = !ov_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (adv_o && div_valid) begin
      if (side2.vacuous) begin
        fo_q <= '0;
        ff_q <= '0;
        fu_q <= ONE_VAL;
      end else begin
        fo_q <= over2[0] ? ONE_VAL : quo2[0];
        ff_q <= over2[1] ? ONE_VAL : quo2[1];
        fu_q <= over2[2] ? ONE_VAL : quo2[2];
      end
      conf_q  <= side2.conflict;
      yager_q <= side2.yager;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (adv_s) sv_q <= in_valid_i;
      if (adv_o) ov_q <= div_valid;
    end
  end

  assign out_valid_o      = ov_q;
  assign fused_occupied_o = fo_q;
  assign fused_free_o     = ff_q;
  assign fused_unknown_o  = fu_q;
  assign conflict_mass_o  = conf_q;
  assign yager_applied_o  = yager_q;

endmodule
`default_nettype wire

// ----- sv/evidence_mass_fusion_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evidence_mass_fusion_top
// Fuses two occupied/free/unknown mass functions with Dempster's rule, or
// Yager's rule at high conflict, and seals the result.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream: one beat carries both input masses (six Q1.15 parts)
//   master stream: one beat carries the sealed fused mass and the conflict,
//   tuser flags that Yager's rule was used
//   APB port: conflict_switch at 0x0, epsilon at 0x4; write only while idle
// Pipeline: 3 front stages, 16 combination divider stages, seal stage,
//   16 normalization divider stages, output register.
// Throughput: one beat per cycle while the master side accepts; the two 16-stage
//   restoring dividers (combination and normalization) set the depth, one quotient bit a stage.
// Reset clears all valid bits and loads the register defaults; the pipeline
//   comes out empty.
// A stalled master side holds its beat; bubbles in the pipeline still fill
//   and s_axis_tready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
module evidence_mass_fusion_top import emf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // a_occupied, a_free, a_unknown, b_occupied, b_free, b_unknown
  input  wire logic [95:0] s_axis_tdata,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // fused_occupied, fused_free, fused_unknown, conflict_mass, zero pad
  output logic [71:0]      m_axis_tdata,
  // yager_applied
  output logic [0:0]       m_axis_tuser
);

  // configuration registers
  logic [SW_W-1:0]  switch_q;
  logic [EPS_W-1:0] eps_q;
  logic             cfg_we;
  emf_reg_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = emf_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_q <= SWITCH_RST;
      eps_q    <= EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CONFLICT_SWITCH: switch_q <= pwdata[SW_W-1:0];
        REG_EPSILON:         eps_q    <= pwdata[EPS_W-1:0];
        default:             ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      REG_CONFLICT_SWITCH: prdata = 32'(switch_q);
      REG_EPSILON:         prdata = 32'(eps_q);
      default:             prdata = '0;
    endcase
  end

  // front stages
  logic                          fr_valid, fr_ready;
  logic [LANES-1:0][SUM_W-1:0]   fr_num;
  logic [PART_W-1:0]             fr_den;
  emf_side_t                     fr_side;

  emf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .conflict_switch_i (switch_q),
    .epsilon_i         (eps_q),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .a_occupied_i      (s_axis_tdata[15:0]),
    .a_free_i          (s_axis_tdata[31:16]),
    .a_unknown_i       (s_axis_tdata[47:32]),
    .b_occupied_i      (s_axis_tdata[63:48]),
    .b_free_i          (s_axis_tdata[79:64]),
    .b_unknown_i       (s_axis_tdata[95:80]),
    .out_valid_o       (fr_valid),
    .out_ready_i       (fr_ready),
    .num_o             (fr_num),
    .den_o             (fr_den),
    .side_o            (fr_side)
  );

  // combination divider
  logic                          cd_valid, cd_ready;
  logic [LANES-1:0][PART_W-1:0]  cd_quo;
  logic [LANES-1:0]              cd_over;
  logic [$bits(emf_side_t)-1:0]  cd_side;

  emf_div_pipe #(
    .LANE_N (LANES),
    .NUM_W  (SUM_W),
    .DEN_W  (PART_W),
    .QUO_W  (PART_W),
    .SIDE_W ($bits(emf_side_t))
  ) u_comb_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .num_i       (fr_num),
    .den_i       (fr_den),
    .side_i      (fr_side),
    .out_valid_o (cd_valid),
    .out_ready_i (cd_ready),
    .quo_o       (cd_quo),
    .over_o      (cd_over),
    .side_o      (cd_side)
  );

  // seal and output register
  logic [PART_W-1:0] fo, ff, fu;
  logic [CONF_W-1:0] conf;
  logic              yager;

  emf_seal u_seal (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .epsilon_i        (eps_q),
    .in_valid_i       (cd_valid),
    .in_ready_o       (cd_ready),
    .quo_i            (cd_quo),
    .over_i           (cd_over),
    .side_i           (emf_side_t'(cd_side)),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .fused_occupied_o (fo),
    .fused_free_o     (ff),
    .fused_unknown_o  (fu),
    .conflict_mass_o  (conf),
    .yager_applied_o  (yager)
  );

  assign m_axis_tdata = {7'b0, conf, fu, ff, fo};
  assign m_axis_tuser = yager;

`ifndef NO_ASSERTIONS
  // dempster only runs below a conflict of one
  a_dempster_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[64:48] < CONF_W'(ONE_VAL))
    else $error("dempster result with conflict at or above one");

  // sealed parts never exceed one
  a_parts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= ONE_VAL && m_axis_tdata[31:16] <= ONE_VAL
                      && m_axis_tdata[47:32] <= ONE_VAL)
    else $error("sealed part above one");

  // input back pressure only with a full, stalled pipeline
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output can move");
`endif

endmodule
`default_nettype wire
